### hw/rtl/mfsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mfsl_pkg: shared definitions for the multi-queue shortest/longest select
// Queue count, default sizes, command and status codes, and the helper that
// maps the active-queue register onto the range of queues that exist.
// ============================================================================
package mfsl_pkg;

    localparam int NUM_QUEUES       = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int ITEM_WIDTH_DEF   = 32;
    localparam int CFG_W            = 4;
    localparam int QIDX_W           = $clog2(NUM_QUEUES);

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(NUM_QUEUES);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // Outcome of one queue operation, handed from the queue control to the
    // result stage.
    typedef struct packed {
        status_t status;
        logic    pop_ok;
    } op_info_t;

    // A register value of zero acts as one queue; values above the number of
    // queues act as all of them.
    function automatic logic [CFG_W-1:0] clamp_active(input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] result;
        result = value;
        if (value == '0) begin
            result = CFG_W'(1);
        end else if (value > CFG_W'(NUM_QUEUES)) begin
            result = CFG_W'(NUM_QUEUES);
        end
        return result;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/mfsl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mfsl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle. Read data is registered and holds its
// value in cycles without a read.
// ============================================================================
module mfsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hw/rtl/mfsl_queue_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mfsl_queue_ctrl: head, tail and count registers of the queue bank
// Decodes one push or pop, updates the addressed queue's pointers and count,
// and drives the slot RAM write and read ports.
// ============================================================================
module mfsl_queue_ctrl #(
    parameter int QUEUE_DEPTH = mfsl_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = mfsl_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int ADDR_W = $clog2(mfsl_pkg::NUM_QUEUES * QUEUE_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        command,
    input  wire logic [mfsl_pkg::QIDX_W-1:0] queue_index,
    input  wire logic [ITEM_WIDTH-1:0]       item_in,
    input  wire logic [mfsl_pkg::CFG_W-1:0]  active_n,
    output logic                             ram_we,
    output logic      [ADDR_W-1:0]           ram_waddr,
    output logic      [ITEM_WIDTH-1:0]       ram_wdata,
    output logic                             ram_re,
    output logic      [ADDR_W-1:0]           ram_raddr,
    output mfsl_pkg::op_info_t               op_info,
    output logic      [CNT_W-1:0]            op_length,
    output logic      [CNT_W-1:0]            counts [mfsl_pkg::NUM_QUEUES]
);
    import mfsl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] head_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg  [NUM_QUEUES];
    logic [CNT_W-1:0] count_next [NUM_QUEUES];

    logic [PTR_W-1:0] cur_head;
    logic [PTR_W-1:0] cur_tail;
    logic [CNT_W-1:0] cur_count;
    logic             in_range;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] result;
        result = ptr + PTR_W'(1);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            result = '0;
        end
        return result;
    endfunction

    assign cur_head  = head_reg[queue_index];
    assign cur_tail  = tail_reg[queue_index];
    assign cur_count = count_reg[queue_index];
    assign in_range  = {1'b0, queue_index} < active_n;

    assign ram_waddr = ADDR_W'(queue_index) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_tail);
    assign ram_raddr = ADDR_W'(queue_index) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
    assign ram_wdata = item_in;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        op_info.status = ST_OK;
        op_info.pop_ok = 1'b0;
        op_length      = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        if (!in_range)
        begin
            op_info.status = ST_BADIDX;
        end
        else if (cmd_t'(command) == CMD_PUSH)
        begin
            if (cur_count == CNT_W'(QUEUE_DEPTH))
            begin
                op_info.status = ST_FULL;
                op_length      = cur_count;
            end
            else
            begin
                ram_we                  = accept;
                op_length               = cur_count + CNT_W'(1);
                if (accept)
                begin
                    tail_next[queue_index]  = ring_next(cur_tail);
                    count_next[queue_index] = cur_count + CNT_W'(1);
                end
            end
        end
        else
        begin
            if (cur_count == '0)
            begin
                op_info.status = ST_EMPTY;
            end
            else
            begin
                ram_re         = accept;
                op_info.pop_ok = 1'b1;
                op_length      = cur_count - CNT_W'(1);
                if (accept)
                begin
                    head_next[queue_index]  = ring_next(cur_head);
                    count_next[queue_index] = cur_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign counts = count_reg;

endmodule
`default_nettype wire

### hw/rtl/mfsl_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mfsl_select: shortest and longest active queue
// Scans the queue counts in index order; strict compares keep the lowest
// index on a tie.
// ============================================================================
module mfsl_select #(
    parameter int QUEUE_DEPTH = mfsl_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic [CNT_W-1:0]           counts [mfsl_pkg::NUM_QUEUES],
    input  wire logic [mfsl_pkg::CFG_W-1:0] active_n,
    output logic      [mfsl_pkg::QIDX_W-1:0] shortest,
    output logic      [mfsl_pkg::QIDX_W-1:0] longest
);
    import mfsl_pkg::*;

    logic [CNT_W-1:0] min_val;
    logic [CNT_W-1:0] max_val;

    always_comb
    begin
        shortest = '0;
        longest  = '0;
        min_val  = counts[0];
        max_val  = counts[0];
        for (int i = 1; i < NUM_QUEUES; i++)
        begin
            if (CFG_W'(i) < active_n)
            begin
                if (counts[i] < min_val)
                begin
                    min_val  = counts[i];
                    shortest = QIDX_W'(i);
                end
                if (counts[i] > max_val)
                begin
                    max_val = counts[i];
                    longest = QIDX_W'(i);
                end
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/multi_fifo_shortest_longest_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multi_fifo_shortest_longest_select: bank of FIFO queues with queue select
// Push/pop onto one of several ring queues and report, after every beat, the
// shortest and longest active queue.
// ============================================================================
// The block takes one input beat per clock cycle while its input is not
// stalled, and returns exactly one result beat for each, in order, through
// the middle stage and the output register. The rate is set by the slot RAM,
// which has one write and one registered read port: each beat does at most
// one of the two, so a new beat enters every cycle unless the input stalls.
// A push writes the payload into the addressed queue's ring; a pop reads the
// head slot, and the popped word comes out of the RAM's read register in the
// next cycle, where the updated queue counts are also compared to find the
// shortest and longest active queue (lowest index wins a tie). The result
// then sits in an output register; the middle stage, kept alongside the RAM
// read register, lets the block take a new beat while a finished result
// waits. The slot RAM holds NUM_QUEUES * QUEUE_DEPTH words and needs no
// clearing pass: a pop only reads slots that a push wrote. The active-queue
// register is written through its own port, which is always ready, and
// should only be changed while no beat is in flight.
// ============================================================================
module multi_fifo_shortest_longest_select #(
    parameter int QUEUE_DEPTH = mfsl_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = mfsl_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration write channel.
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [mfsl_pkg::CFG_W-1:0]   cfg_data,
    // Input channel.
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [mfsl_pkg::QIDX_W-1:0]  queue_index,
    input  wire logic [ITEM_WIDTH-1:0]        item_in,
    // Output channel.
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [ITEM_WIDTH-1:0]        item_out,
    output logic      [1:0]                   status,
    output logic      [mfsl_pkg::QIDX_W-1:0]  shortest_queue,
    output logic      [mfsl_pkg::QIDX_W-1:0]  longest_queue,
    output logic      [CNT_W-1:0]             addressed_length
);
    import mfsl_pkg::*;

    localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    // Configuration register.
    logic [CFG_W-1:0] active_reg;
    logic [CFG_W-1:0] active_next;
    logic [CFG_W-1:0] active_n;

    // Handshake.
    logic in_accept;
    logic b_advance;

    // Queue control and RAM.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;
    op_info_t              op_info;
    logic [CNT_W-1:0]      op_length;
    logic [CNT_W-1:0]      counts [NUM_QUEUES];
    logic [QIDX_W-1:0]     sel_shortest;
    logic [QIDX_W-1:0]     sel_longest;

    // Middle stage: waits for the RAM read and the updated counts.
    logic             b_valid_reg;
    logic             b_valid_next;
    op_info_t         b_info_reg;
    logic [CNT_W-1:0] b_length_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ITEM_WIDTH-1:0] item_out_reg;
    status_t               status_reg;
    logic [QIDX_W-1:0]     shortest_reg;
    logic [QIDX_W-1:0]     longest_reg;
    logic [CNT_W-1:0]      length_reg;

    // The configuration port never pushes back.
    assign cfg_ready   = 1'b1;
    assign active_next = (cfg_valid && cfg_ready) ? cfg_data : active_reg;
    assign active_n    = clamp_active(active_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // The middle stage moves on whenever the output register is empty or is
    // being emptied. A new beat is taken whenever the middle stage is free or
    // moving on; while it is held, the counts and the RAM read register stay
    // put because nothing new is accepted.
    assign b_advance = b_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = b_valid_reg && !b_advance;
    assign in_accept = in_valid && !in_stall;

    mfsl_queue_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .command     (command),
        .queue_index (queue_index),
        .item_in     (item_in),
        .active_n    (active_n),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .op_info     (op_info),
        .op_length   (op_length),
        .counts      (counts)
    );

    mfsl_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The count registers already hold the state after the beat in the
    // middle stage, so the select works on them directly.
    mfsl_select #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_select (
        .counts   (counts),
        .active_n (active_n),
        .shortest (sel_shortest),
        .longest  (sel_longest)
    );

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_accept)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_advance)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (b_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_info_reg   <= op_info;
            b_length_reg <= op_length;
        end
        if (b_advance)
        begin
            item_out_reg <= b_info_reg.pop_ok ? ram_rdata : '0;
            status_reg   <= b_info_reg.status;
            shortest_reg <= sel_shortest;
            longest_reg  <= sel_longest;
            length_reg   <= b_length_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign item_out         = item_out_reg;
    assign status           = status_reg;
    assign shortest_queue   = shortest_reg;
    assign longest_queue    = longest_reg;
    assign addressed_length = length_reg;

    // A beat taken at one edge is always waiting in the middle stage after it.
    a_accept_lands : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> b_valid_reg
    ) else $error("accepted beat did not reach the middle stage");

    // Only a successful pop carries a payload.
    a_payload_only_on_pop : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status_t'(status) != ST_OK)) |-> (item_out == '0)
    ) else $error("payload on a result that is not a successful pop");

    // A bad index leaves a zero length.
    a_badidx_length : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status_t'(status) == ST_BADIDX)) |-> (addressed_length == '0)
    ) else $error("nonzero length reported for a bad index");

    // A queue never reports more entries than its ring holds.
    a_length_bound : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (addressed_length <= CNT_W'(QUEUE_DEPTH))
    ) else $error("queue length beyond ring depth");

endmodule
`default_nettype wire

### test/multi_fifo_shortest_longest_select_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_fifo_shortest_longest_select_tb: self-checking bench for the queue bank
// Drives push and pop beats with random idling on both channels and rewrites
// the active-queue register between traffic phases. A scoreboard keeps its own
// copy of every ring and predicts each result beat, field by field.
// ============================================================================
module multi_fifo_shortest_longest_select_tb;

    import mfsl_pkg::*;

    localparam int ITEM_W = ITEM_WIDTH_DEF;
    localparam int LEN_W  = $clog2(QUEUE_DEPTH_DEF + 1);

    // The slowest correct run: 1279 beats, each behind the longest sender gap
    // and the longest receiver stall, plus the pipeline, one long hold-off and
    // the pauses around each register write. The limit leaves plenty of room
    // above that.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_BEATS = 125;

    // Register values visited after the reset phase. Zero must act as one
    // queue and anything above the queue count as all of them.
    localparam logic [CFG_W-1:0] ACTIVE_PLAN [9] =
        '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9, 4'd2, 4'd7};

    typedef struct {
        logic [ITEM_W-1:0] item;
        status_t           status;
        logic [QIDX_W-1:0] shortest;
        logic [QIDX_W-1:0] longest;
        logic [LEN_W-1:0]  length;
    } bank_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the rings and the active-queue register, and holds
    // the results still owed by the block in arrival order.
    // ------------------------------------------------------------------------
    class queue_select_scoreboard;
        logic [ITEM_W-1:0] ring_items [NUM_QUEUES][$];
        logic [CFG_W-1:0]  active_reg;
        bank_result_t      owed_results [$];
        int unsigned       errors;

        function new();
            active_reg = ACTIVE_RESET;
            errors     = 0;
        endfunction

        function void set_active(logic [CFG_W-1:0] value);
            active_reg = value;
        endfunction

        function int unsigned queues_in_use();
            if (active_reg == 0)
                return 1;
            if (active_reg > NUM_QUEUES)
                return NUM_QUEUES;
            return active_reg;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Predicts the result of one accepted input beat.
        function void note_beat(logic cmd, logic [QIDX_W-1:0] idx, logic [ITEM_W-1:0] payload);
            bank_result_t r;
            int unsigned  span;
            int unsigned  q;
            span       = queues_in_use();
            r.item     = '0;
            r.status   = ST_OK;
            r.shortest = '0;
            r.longest  = '0;
            r.length   = '0;
            if (idx >= span) begin
                r.status = ST_BADIDX;
            end else if (cmd == CMD_PUSH) begin
                if (ring_items[idx].size() >= QUEUE_DEPTH_DEF)
                    r.status = ST_FULL;
                else
                    ring_items[idx].push_back(payload);
                r.length = LEN_W'(ring_items[idx].size());
            end else begin
                if (ring_items[idx].size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.item = ring_items[idx].pop_front();
                r.length = LEN_W'(ring_items[idx].size());
            end
            // Strict comparisons keep the lowest index on a tie.
            for (q = 1; q < span; q++) begin
                if (ring_items[q].size() < ring_items[r.shortest].size())
                    r.shortest = QIDX_W'(q);
                if (ring_items[q].size() > ring_items[r.longest].size())
                    r.longest = QIDX_W'(q);
            end
            owed_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [ITEM_W-1:0] want,
                                    logic [ITEM_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [ITEM_W-1:0] item, logic [1:0] stat,
                                   logic [QIDX_W-1:0] shortest, logic [QIDX_W-1:0] longest,
                                   logic [LEN_W-1:0] length);
            bank_result_t want;
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual item %0h status %0d",
                         $time, item, stat);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("item_out", want.item, item);
            compare_field("status", ITEM_W'(want.status), ITEM_W'(stat));
            compare_field("shortest_queue", ITEM_W'(want.shortest), ITEM_W'(shortest));
            compare_field("longest_queue", ITEM_W'(want.longest), ITEM_W'(longest));
            compare_field("addressed_length", ITEM_W'(want.length), ITEM_W'(length));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [QIDX_W-1:0]   queue_index;
    logic [ITEM_W-1:0]   item_in;
    logic                out_valid;
    logic                out_stall;
    logic [ITEM_W-1:0]   item_out;
    logic [1:0]          status;
    logic [QIDX_W-1:0]   shortest_queue;
    logic [QIDX_W-1:0]   longest_queue;
    logic [LEN_W-1:0]    addressed_length;

    queue_select_scoreboard sb;

    // Idling control shared between the stimulus and the receiver process.
    // A steady flag turns off idling on that side for the current burst.
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          hold_off_req    = 1'b0;
    int unsigned cycle_count     = 0;

    multi_fifo_shortest_longest_select u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .queue_index      (queue_index),
        .item_in          (item_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_out         (item_out),
        .status           (status),
        .shortest_queue   (shortest_queue),
        .longest_queue    (longest_queue),
        .addressed_length (addressed_length)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Payloads lean on the extremes now and then.
    function automatic logic [ITEM_W-1:0] pick_payload();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return ITEM_W'($urandom);
    endfunction

    // All handshakes are observed here, at the clock edge, before any of the
    // values driven at that edge take effect. Noting the input beat and
    // checking the output beat in one process keeps their order fixed.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_active(cfg_data);
            if (in_valid && !in_stall)
                sb.note_beat(command, queue_index, item_in);
            if (out_valid && !out_stall)
                sb.check_result(item_out, status, shortest_queue, longest_queue,
                                addressed_length);
        end
    end

    // Receiver. Random stalls of mixed length, and on request one long
    // hold-off counted here while the sender keeps offering beats, so the
    // pipeline fills and the block has to stall its input.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req && hold_left == 0) begin
                hold_left    = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (!receiver_steady && $urandom_range(0, 99) < 30)
                    stall_left = pick_pause();
            end
        end
    end

    // Offers one beat after an optional gap and returns at the edge where it
    // is taken. Valid stays high into the next beat when there is no gap.
    task automatic offer_beat(input logic cmd, input logic [QIDX_W-1:0] idx,
                              input logic [ITEM_W-1:0] payload);
        int unsigned gap;
        gap = sender_steady ? 0 : pick_pause();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        queue_index <= idx;
        item_in     <= payload;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stops offering and waits until every owed result has come back. Each
    // beat gives exactly one result, so a short pause after that is enough.
    task automatic settle_queue_bank();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the active-queue register; only called while the bank is idle.
    task automatic write_active_queues(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic in bursts of 32 beats. Each burst leans toward filling,
    // draining or a mix, and often aims at one queue so that rings reach full
    // and empty. A few beats use any index to hit inactive queues.
    task automatic run_traffic(input int unsigned beats, input bit with_hold);
        int unsigned       span;
        int unsigned       push_pct;
        int unsigned       k;
        logic [QIDX_W-1:0] focus_q;
        logic [QIDX_W-1:0] idx;
        logic              cmd;
        bit                focused;
        span     = sb.queues_in_use();
        push_pct = 50;
        focus_q  = '0;
        focused  = 1'b0;
        for (k = 0; k < beats; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                focus_q         = QIDX_W'($urandom_range(0, span - 1));
                focused         = ($urandom_range(0, 99) < 60);
                sender_steady   = ($urandom_range(0, 3) == 0);
                receiver_steady = ($urandom_range(0, 3) == 0);
            end
            if (with_hold && k == 40)
                hold_off_req = 1'b1;
            if ($urandom_range(0, 99) < 8)
                idx = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
            else if (focused)
                idx = focus_q;
            else
                idx = QIDX_W'($urandom_range(0, span - 1));
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            offer_beat(cmd, idx, pick_payload());
        end
    endtask

    initial
    begin : stimulus
        int unsigned k;
        sb          = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_PUSH;
        queue_index = '0;
        item_in     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with all eight queues active: pop on an empty ring,
        // payload extremes through queue 0, the top index, then one ring
        // filled to its depth and pushed once more to see the drop.
        offer_beat(CMD_POP, 3'd0, ITEM_W'($urandom));
        offer_beat(CMD_PUSH, 3'd0, '0);
        offer_beat(CMD_PUSH, 3'd0, '1);
        offer_beat(CMD_PUSH, 3'd7, 32'hA5A5_5A5A);
        offer_beat(CMD_POP, 3'd0, ITEM_W'($urandom));
        offer_beat(CMD_POP, 3'd0, ITEM_W'($urandom));
        offer_beat(CMD_POP, 3'd0, ITEM_W'($urandom));
        for (k = 0; k <= QUEUE_DEPTH_DEF; k++)
            offer_beat(CMD_PUSH, 3'd3, pick_payload());

        // First random phase at the reset setting, with the long hold-off.
        run_traffic(PHASE_BEATS + 5, 1'b1);

        // Later phases walk through the register values. Lowering the count
        // leaves the upper rings filled, and raising it brings them back.
        foreach (ACTIVE_PLAN[p]) begin
            settle_queue_bank();
            write_active_queues(ACTIVE_PLAN[p]);
            run_traffic(PHASE_BEATS, 1'b0);
        end

        settle_queue_bank();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
